@@ hdl/cpmf_pkg.sv @@
package cpmf_pkg;

  localparam int unsigned CPMF_MAX_WIDTH    = 256;
  localparam int unsigned CPMF_WIDTH_RST    = 256;
  localparam int unsigned CPMF_HEIGHT_RST   = 256;
  localparam int unsigned CPMF_HEIGHT_LIMIT = 4096;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned FW_W    = 9;
  localparam int unsigned FH_W    = 13;
  localparam int unsigned ROW_W   = 12;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered_pixel;
    logic             last_of_frame;
  } out_t;

  // one column of both row buffers
  typedef struct packed {
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] two_above;
  } cell_data_t;

  // neighborhood handed to the filter kernel
  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] d;
    logic [PIX_W-1:0] e;
  } cross_win_t;

endpackage

@@ hdl/cpmf_cell.sv @@
module cpmf_cell
  import cpmf_pkg::*;
(
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic       is_tail_i,
  input  cell_data_t next_i,
  input  cell_data_t ins_i,
  output cell_data_t data_o
);

  cell_data_t data_q, data_d;

  assign data_d = is_tail_i ? ins_i : next_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

@@ hdl/cpmf_cross.sv @@
module cpmf_cross
  import cpmf_pkg::*;
(
  input  cross_win_t       win_i,
  output logic [PIX_W-1:0] result_o
);

  function automatic logic [PIX_W-1:0] lo(input logic [PIX_W-1:0] x,
                                          input logic [PIX_W-1:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic [PIX_W-1:0] hi(input logic [PIX_W-1:0] x,
                                          input logic [PIX_W-1:0] y);
    return (x > y) ? x : y;
  endfunction

  logic [PIX_W-1:0] vmx, vmn, hmx, hmn;
  logic [PIX_W:0]   sum;

  always_comb begin
    vmx = hi(lo(win_i.a, win_i.b), lo(win_i.b, win_i.c));
    vmn = lo(hi(win_i.a, win_i.b), hi(win_i.b, win_i.c));
    hmx = hi(lo(win_i.d, win_i.b), lo(win_i.b, win_i.e));
    hmn = lo(hi(win_i.d, win_i.b), hi(win_i.b, win_i.e));
    sum = {1'b0, hi(vmx, hmx)} + {1'b0, lo(vmn, hmn)};
  end

  assign result_o = sum[PIX_W:1];

endmodule

@@ hdl/cpmf_skid.sv @@
module cpmf_skid
  import cpmf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic out_valid_q, skid_valid_q;
  out_t out_q, skid_q;
  logic take;

  assign take = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (!out_valid_q) begin
      out_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= data_i;
      end
    end else if (!out_valid_q) begin
      if (push_i) begin
        out_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/cross_pseudo_median_filter.sv @@
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_data_i  (operation, pixel)
// out      output     out_valid_o / out_stall_i out_data_o (filtered_pixel, last_of_frame)
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One transaction per clock unless stalled; a result shows on a free out in the next cycle.
// Row buffers are a chain of MAX_WIDTH cells that rotates by one column per pixel or flush
// that is not ignored; the filter kernel reads the head cell and its neighbor.
// Reset clears position and output flags and loads the default config; no clearing pass is run.
// A two-entry output buffer keeps input accepted while out stalls, until its second entry fills.
module cross_pseudo_median_filter
  import cpmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = CPMF_MAX_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WIDTH_RST_EFF =
    (MAX_WIDTH < CPMF_WIDTH_RST) ? MAX_WIDTH : CPMF_WIDTH_RST;
  localparam logic [CW-1:0]    WLAST_RST = CW'(WIDTH_RST_EFF - 1);
  localparam logic [ROW_W-1:0] HLAST_RST = ROW_W'(CPMF_HEIGHT_RST - 1);

  logic [CW-1:0]    wlast_q, col_q;
  logic [ROW_W-1:0] hlast_q, row_q;
  logic             flushing_q;
  logic [PIX_W-1:0] left_q;

  logic             accept, is_pix, is_flush, step, emit, col_last;
  logic [FW_W-1:0]  w_cfg;
  logic [FH_W-1:0]  h_cfg;
  cell_data_t       cells [MAX_WIDTH];
  cell_data_t       ins;
  cross_win_t       win;
  logic [PIX_W-1:0] kernel_res;
  out_t             res;
  logic             skid_full;

  assign accept   = in_valid_i & ~in_stall_o;
  assign is_pix   = accept & (in_data_i.operation == OP_PIXEL) & ~flushing_q;
  assign is_flush = accept & (in_data_i.operation == OP_FLUSH) & flushing_q;
  assign step     = is_pix | is_flush;
  assign emit     = is_flush | (is_pix & (row_q != '0));
  assign col_last = (col_q == wlast_q);

  assign w_cfg = cfg_wdata_i[FW_W-1:0];
  assign h_cfg = cfg_wdata_i[FH_W-1:0];

  always_comb begin
    if (flushing_q) begin
      ins = cells[0];
    end else begin
      ins.above     = in_data_i.pixel;
      ins.two_above = cells[0].above;
    end
  end

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    cell_data_t nxt;
    if (k == MAX_WIDTH - 1) begin : g_end
      assign nxt = ins;
    end else begin : g_mid
      assign nxt = cells[k+1];
    end
    cpmf_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (step),
      .is_tail_i (wlast_q == CW'(k)),
      .next_i    (nxt),
      .ins_i     (ins),
      .data_o    (cells[k])
    );
  end

  always_comb begin
    win.b = cells[0].above;
    if (flushing_q ? (row_q == '0) : (row_q == ROW_W'(1))) begin
      win.a = win.b;
    end else begin
      win.a = cells[0].two_above;
    end
    win.c = flushing_q ? win.b : in_data_i.pixel;
    win.d = (col_q == '0) ? win.b : left_q;
    win.e = col_last ? win.b : cells[1].above;
  end

  cpmf_cross u_cross (
    .win_i    (win),
    .result_o (kernel_res)
  );

  assign res.filtered_pixel = kernel_res;
  assign res.last_of_frame  = is_flush & col_last;

  cpmf_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .data_i      (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = skid_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q    <= WLAST_RST;
      hlast_q    <= HLAST_RST;
      col_q      <= '0;
      row_q      <= '0;
      flushing_q <= 1'b0;
      left_q     <= '0;
    end else if (cfg_we_i) begin
      col_q      <= '0;
      row_q      <= '0;
      flushing_q <= 1'b0;
      left_q     <= '0;
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH: begin
          if (w_cfg == '0) begin
            wlast_q <= '0;
          end else if (32'(w_cfg) > 32'(MAX_WIDTH)) begin
            wlast_q <= CW'(MAX_WIDTH - 1);
          end else begin
            wlast_q <= CW'(w_cfg - FW_W'(1));
          end
        end
        REG_FRAME_HEIGHT: begin
          if (h_cfg == '0) begin
            hlast_q <= '0;
          end else if (32'(h_cfg) > 32'(CPMF_HEIGHT_LIMIT)) begin
            hlast_q <= ROW_W'(CPMF_HEIGHT_LIMIT - 1);
          end else begin
            hlast_q <= ROW_W'(h_cfg - FH_W'(1));
          end
        end
        default: begin
        end
      endcase
    end else if (step) begin
      if (emit && !(is_flush && col_last)) begin
        left_q <= win.b;
      end
      if (!col_last) begin
        col_q <= col_q + CW'(1);
      end else begin
        col_q <= '0;
        if (is_flush) begin
          row_q      <= '0;
          flushing_q <= 1'b0;
          left_q     <= '0;
        end else if (row_q == hlast_q) begin
          flushing_q <= 1'b1;
        end else begin
          row_q <= row_q + ROW_W'(1);
        end
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full |-> out_valid_o)
    else $error("output buffer overflow entry without head entry");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= wlast_q)
    else $error("column position beyond frame width");

  a_flush_on_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing_q |-> (row_q == hlast_q))
    else $error("flush phase outside the last row");

  a_last_ends_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_flush && col_last && !cfg_we_i) |=> (!flushing_q && col_q == '0 && row_q == '0))
    else $error("frame did not restart after final result");

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  import cpmf_pkg::*;

  localparam int unsigned IDLE_PCT      = 23;
  localparam int unsigned RANDOM_ITEMS  = 750;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS   = 100;
  localparam int unsigned IDX_W         = $clog2(CPMF_MAX_WIDTH);

  localparam logic [PIX_W-1:0] EDGE_PIXELS [9] = '{
    8'h00, 8'hFF, 8'h00,
    8'hFF, 8'h00, 8'hFF,
    8'h80, 8'h7F, 8'h01
  };

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  cfg_reg_e         cfg_idx_i   = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_t              in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_data_o;

  cross_pseudo_median_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // filter state mirrored in the testbench
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  logic [PIX_W-1:0] above_row     [CPMF_MAX_WIDTH];
  logic [PIX_W-1:0] two_above_row [CPMF_MAX_WIDTH];
  logic [PIX_W-1:0] left_px;
  int unsigned      col_pos;
  int unsigned      row_pos;
  bit               flushing;

  out_t        filtered_q [$];
  out_t        want_px;
  int unsigned fail_count = 0;
  int unsigned work_items = 0;
  bit          no_gaps    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [PIX_W-1:0] min_px(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic [PIX_W-1:0] max_px(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
    return (x > y) ? x : y;
  endfunction

  function automatic logic [PIX_W-1:0] cross_median(
    logic [PIX_W-1:0] a, logic [PIX_W-1:0] b, logic [PIX_W-1:0] c,
    logic [PIX_W-1:0] d, logic [PIX_W-1:0] e
  );
    logic [PIX_W-1:0] v_hi, v_lo, h_hi, h_lo;
    logic [PIX_W:0]   sum;
    v_hi = max_px(min_px(a, b), min_px(b, c));
    v_lo = min_px(max_px(a, b), max_px(b, c));
    h_hi = max_px(min_px(d, b), min_px(b, e));
    h_lo = min_px(max_px(d, b), max_px(b, e));
    sum  = {1'b0, max_px(v_hi, h_hi)} + {1'b0, min_px(v_lo, h_lo)};
    return sum[PIX_W:1];
  endfunction

  function automatic int unsigned frame_w();
    if (width_reg == '0) return 1;
    if (32'(width_reg) > CPMF_MAX_WIDTH) return CPMF_MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned frame_h();
    if (height_reg == '0) return 1;
    if (32'(height_reg) > CPMF_HEIGHT_LIMIT) return CPMF_HEIGHT_LIMIT;
    return 32'(height_reg);
  endfunction

  function automatic logic [PIX_W-1:0] filter_at(
    int unsigned col, int unsigned w, int unsigned emitted_row, logic [PIX_W-1:0] below
  );
    logic [PIX_W-1:0] a, b, d, e;
    b = above_row[IDX_W'(col)];
    a = (emitted_row == 0) ? b : two_above_row[IDX_W'(col)];
    d = (col == 0) ? b : left_px;
    e = (col + 1 < w) ? above_row[IDX_W'(col + 1)] : b;
    left_px = b;
    return cross_median(a, b, below, d, e);
  endfunction

  function automatic void restart_frame();
    left_px  = '0;
    col_pos  = 0;
    row_pos  = 0;
    flushing = 1'b0;
  endfunction

  function automatic void advance_filter(in_t item);
    int unsigned w, h, col;
    out_t        res;
    w   = frame_w();
    h   = frame_h();
    col = (col_pos >= w) ? w - 1 : col_pos;
    if (item.operation == OP_PIXEL) begin
      if (flushing) return;
      if (row_pos > 0) begin
        res.filtered_pixel = filter_at(col, w, row_pos - 1, item.pixel);
        res.last_of_frame  = 1'b0;
        filtered_q.push_back(res);
      end
      two_above_row[IDX_W'(col)] = above_row[IDX_W'(col)];
      above_row[IDX_W'(col)]     = item.pixel;
      if (col + 1 < w) begin
        col_pos = col + 1;
      end else begin
        col_pos = 0;
        if (row_pos + 1 < h) row_pos++;
        else flushing = 1'b1;
      end
    end else if (flushing) begin
      res.filtered_pixel = filter_at(col, w, row_pos, above_row[IDX_W'(col)]);
      res.last_of_frame  = (col + 1 >= w);
      filtered_q.push_back(res);
      if (col + 1 < w) col_pos = col + 1;
      else restart_frame();
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (fail_count < MAX_REPORTS)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // result side: random stall, compare each result taken from out in order
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data_o.filtered_pixel), 0);
      end else begin
        want_px = filtered_q.pop_front();
        if (out_data_o.filtered_pixel !== want_px.filtered_pixel)
          report_mismatch("filtered_pixel", 32'(out_data_o.filtered_pixel),
                          32'(want_px.filtered_pixel));
        if (out_data_o.last_of_frame !== want_px.last_of_frame)
          report_mismatch("last_of_frame", 32'(out_data_o.last_of_frame),
                          32'(want_px.last_of_frame));
      end
    end
    out_stall_i <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
  end

  task automatic send_item(op_e op, logic [PIX_W-1:0] px);
    in_t item;
    bit  ignored;
    item.operation = op;
    item.pixel     = px;
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ignored = (op == OP_PIXEL) ? flushing : !flushing;
    if (!ignored) work_items++;
    advance_filter(item);
  endtask

  task automatic drain_results();
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    in_valid_i <= 1'b0;
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
    else height_reg = val;
    restart_frame();
  endtask

  task automatic set_geometry(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw);
    write_reg(REG_FRAME_WIDTH, w_raw);
    write_reg(REG_FRAME_HEIGHT, h_raw);
  endtask

  function automatic logic [PIX_W-1:0] rand_px();
    case ($urandom_range(0, 3))
      0, 1:    return PIX_W'($urandom_range(0, 255));
      2:       return PIX_W'(100 + $urandom_range(0, 3));
      default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic send_frame();
    repeat (frame_w() * frame_h()) send_item(OP_PIXEL, rand_px());
    repeat (frame_w()) send_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
  endtask

  // reset geometry: full first row at max width, a few results from row 1
  task automatic test_default_geometry();
    repeat (CPMF_WIDTH_RST + 8) send_item(OP_PIXEL, rand_px());
  endtask

  task automatic test_directed_small();
    set_geometry(3, 3);
    send_item(OP_FLUSH, 8'hFF);
    foreach (EDGE_PIXELS[i]) send_item(OP_PIXEL, EDGE_PIXELS[i]);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_PIXEL, 8'h55);
    send_item(OP_FLUSH, 8'hAA);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_FLUSH, 8'hFF);
  endtask

  task automatic test_degenerate_sizes();
    set_geometry(0, 0);
    send_frame();
    send_item(OP_FLUSH, 8'h0F);
    set_geometry(1, 3);
    send_frame();
    set_geometry(2, 1);
    send_frame();
    set_geometry(13'h1E05, 2);
    send_frame();
  endtask

  task automatic test_extreme_sizes();
    set_geometry(13'h1FF, 1);
    send_frame();
    set_geometry(1, 13'h1FFF);
    repeat (40) send_item(OP_PIXEL, rand_px());
  endtask

  task automatic test_restart_mid_frame();
    set_geometry(4, 4);
    repeat (6) send_item(OP_PIXEL, rand_px());
    write_reg(REG_FRAME_HEIGHT, 3);
    send_frame();
    repeat (12) send_item(OP_PIXEL, rand_px());
    repeat (2) send_item(OP_FLUSH, rand_px());
    write_reg(REG_FRAME_WIDTH, 5);
    send_frame();
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    set_geometry(12, 8);
    send_frame();
    send_frame();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned base, w, h, n, cut;
    bit          dirty;
    base  = work_items;
    dirty = 1'b1;
    while (work_items < base + RANDOM_ITEMS) begin
      if (dirty || $urandom_range(0, 99) < 60) begin
        n = $urandom_range(0, 99);
        if (n < 70) w = $urandom_range(1, 8);
        else if (n < 95) w = $urandom_range(9, 40);
        else w = $urandom_range(200, 256);
        h = (w > 100) ? $urandom_range(1, 2) : $urandom_range(1, 8);
        set_geometry(CFG_W'(w), CFG_W'(h));
        dirty = 1'b0;
      end
      n   = frame_w() * frame_h();
      cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, n - 1) : n;
      for (int i = 0; i < cut; i++) begin
        if ($urandom_range(0, 99) < 5) send_item(OP_FLUSH, rand_px());
        send_item(OP_PIXEL, rand_px());
      end
      if (cut < n) begin
        dirty = 1'b1;
        continue;
      end
      for (int i = 0; i < frame_w(); i++) begin
        if ($urandom_range(0, 99) < 5) send_item(OP_PIXEL, rand_px());
        send_item(OP_FLUSH, rand_px());
      end
      if ($urandom_range(0, 9) == 0) send_item(OP_FLUSH, rand_px());
    end
  endtask

  initial begin
    width_reg  = CPMF_WIDTH_RST;
    height_reg = CPMF_HEIGHT_RST;
    foreach (above_row[i]) begin
      above_row[i]     = '0;
      two_above_row[i] = '0;
    end
    restart_frame();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_geometry();
    test_directed_small();
    test_degenerate_sizes();
    test_extreme_sizes();
    test_restart_mid_frame();
    test_back_to_back();
    test_random_frames();

    in_valid_i <= 1'b0;
    drain_results();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/cpmf_pkg.sv
hdl/cpmf_cell.sv
hdl/cpmf_cross.sv
hdl/cpmf_skid.sv
hdl/cross_pseudo_median_filter.sv
sim/tb_top.sv
